[hdl/id3p_pkg.sv]
// ---------------------------------------------------------------------------
// id3p_pkg
// Shared types, codes and constants of the ID3v2 tag stream parser.
// ---------------------------------------------------------------------------
package id3p_pkg;

    // Parser phases
    localparam logic [1:0] PH_HEADER   = 2'd0;
    localparam logic [1:0] PH_FRAMEHDR = 2'd1;
    localparam logic [1:0] PH_BODY     = 2'd2;
    localparam logic [1:0] PH_DONE     = 2'd3;

    // Status codes
    localparam logic [2:0] ST_PARSING     = 3'd0;
    localparam logic [2:0] ST_DONE        = 3'd1;
    localparam logic [2:0] ST_NO_TAG      = 3'd2;
    localparam logic [2:0] ST_INVALID     = 3'd3;
    localparam logic [2:0] ST_UNSUPPORTED = 3'd4;

    // Field kinds
    localparam logic [2:0] KIND_SKIP    = 3'd0;
    localparam logic [2:0] KIND_COMMENT = 3'd1;
    localparam logic [2:0] KIND_ALBUM   = 3'd2;
    localparam logic [2:0] KIND_ARTIST  = 3'd3;
    localparam logic [2:0] KIND_TITLE   = 3'd4;
    localparam logic [2:0] KIND_TRACK   = 3'd5;
    localparam logic [2:0] KIND_YEAR    = 3'd6;
    localparam logic [2:0] KIND_PICTURE = 3'd7;

    // Subfield steps; content follows once SUB_CONTENT is reached
    localparam logic [2:0] SUB_START   = 3'd0;
    localparam logic [2:0] SUB_LANG_END = 3'd4;
    localparam logic [2:0] SUB_MIME    = 3'd1;
    localparam logic [2:0] SUB_PICTYPE = 3'd2;
    localparam logic [2:0] SUB_DESC    = 3'd3;
    localparam logic [2:0] SUB_CONTENT = 3'd5;

    // Header constants
    localparam logic [7:0] MAGIC_I     = 8'h49;
    localparam logic [7:0] MAGIC_D     = 8'h44;
    localparam logic [7:0] MAGIC_3     = 8'h33;
    localparam logic [7:0] FLAG_REJECT = 8'h60 | 8'h1F;

    // Known frame IDs
    localparam logic [31:0] ID_COMM = 32'h434F_4D4D;
    localparam logic [31:0] ID_TALB = 32'h5441_4C42;
    localparam logic [31:0] ID_TPE1 = 32'h5450_4531;
    localparam logic [31:0] ID_TIT2 = 32'h5449_5432;
    localparam logic [31:0] ID_TRCK = 32'h5452_434B;
    localparam logic [31:0] ID_TYER = 32'h5459_4552;
    localparam logic [31:0] ID_APIC = 32'h4150_4943;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       start_of_file;
    } in_t;

    typedef struct packed {
        logic [2:0] field_kind;
        logic [7:0] payload_byte;
        logic       last_of_field;
        logic [2:0] status;
    } out_t;

    typedef struct packed {
        logic [1:0]  phase;
        logic [3:0]  header_count;
        logic [27:0] tag_remaining;
        logic [31:0] frame_remaining;
        logic [31:0] frame_id;
        logic [2:0]  frame_kind;
        logic [2:0]  subfield_phase;
        logic [2:0]  parse_status;
    } state_t;

    localparam state_t STATE_RESET = '{
        phase:           PH_HEADER,
        header_count:    4'd0,
        tag_remaining:   28'd0,
        frame_remaining: 32'd0,
        frame_id:        32'd0,
        frame_kind:      KIND_SKIP,
        subfield_phase:  SUB_START,
        parse_status:    ST_PARSING
    };

    // Map a frame ID to its field kind
    function automatic logic [2:0] classify(input logic [31:0] id);
        logic [2:0] k;
        k = KIND_SKIP;
        if (id == ID_COMM) k = KIND_COMMENT;
        else if (id == ID_TALB) k = KIND_ALBUM;
        else if (id == ID_TPE1) k = KIND_ARTIST;
        else if (id == ID_TIT2) k = KIND_TITLE;
        else if (id == ID_TRCK) k = KIND_TRACK;
        else if (id == ID_TYER) k = KIND_YEAR;
        else if (id == ID_APIC) k = KIND_PICTURE;
        return k;
    endfunction

endpackage

[hdl/id3v2_tag_stream_parser.sv]
// ---------------------------------------------------------------------------
// id3v2_tag_stream_parser
// Byte-stream ID3v2.3/2.4 tag parser, one result per input byte.
// ---------------------------------------------------------------------------
// Accepts one file byte per cycle unless the output stalls, and returns one
// result per byte in the cycle after, through an output register; a new byte
// is taken whenever the output register is empty or being drained, so
// throughput is one byte per clock. The cycle is set by the per-byte step
// logic (a 32-bit frame-size decrement and zero test, plus header compares).
// Assert start_of_file on the first byte of each file to restart the parser.
module id3v2_tag_stream_parser import id3p_pkg::*; (
    input  logic aclk,
    input  logic aresetn,
    input  logic s_valid,
    output logic s_ready,
    input  in_t  s_data,
    output logic m_valid,
    input  logic m_ready,
    output out_t m_data
);

    state_t state_reg;
    state_t state_next;
    out_t   m_data_reg;
    out_t   m_data_next;
    logic   m_valid_reg;
    logic   s_accept;

    // accept while the output register is free or draining
    assign s_ready  = !m_valid_reg || m_ready;
    assign s_accept = s_valid && s_ready;

    id3p_step u_step (
        .cur     (state_reg),
        .in_item (s_data),
        .nxt     (state_next),
        .res     (m_data_next)
    );

    // advance parser state on each transaction
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= STATE_RESET;
        end else if (s_accept) begin
            state_reg <= state_next;
        end
    end

    // hold result until taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s_accept) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            m_data_reg <= m_data_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // a finished parser always holds a nonzero status
    a_done_status: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg.phase == PH_DONE |-> state_reg.parse_status != ST_PARSING)
        else $error("finished parser without status");

    // header failures never carry content
    a_fail_no_content: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_data.status == ST_NO_TAG || m_data.status == ST_INVALID ||
                    m_data.status == ST_UNSUPPORTED)
        |-> m_data.field_kind == KIND_SKIP && !m_data.last_of_field)
        else $error("content reported with a header failure");

    // content only arrives while a frame body is parsed
    a_content_body: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept && !s_data.start_of_file && state_reg.phase != PH_BODY
        |=> m_data.field_kind == KIND_SKIP && !m_data.last_of_field)
        else $error("content outside a frame body");

endmodule

[hdl/id3p_step.sv]
// ---------------------------------------------------------------------------
// id3p_step
// Per-byte parse logic: next parser state and result for one input byte.
// ---------------------------------------------------------------------------
module id3p_step import id3p_pkg::*; (
    input  state_t cur,
    input  in_t    in_item,
    output state_t nxt,
    output out_t   res
);

    logic [7:0] b;
    logic [3:0] n;
    state_t     s;
    logic [2:0] kind;
    logic [7:0] pay;
    logic       last;

    assign b = in_item.data_byte;

    always_comb begin
        // restart on the first byte of a file
        s    = in_item.start_of_file ? STATE_RESET : cur;
        n    = s.header_count;
        kind = KIND_SKIP;
        pay  = 8'd0;
        last = 1'b0;

        case (s.phase)
            PH_HEADER: begin
                // check magic, version, flags, then collect syncsafe size
                if (n == 4'd0) begin
                    if (b != MAGIC_I) begin
                        s.phase = PH_DONE; s.parse_status = ST_NO_TAG;
                    end
                end else if (n == 4'd1) begin
                    if (b != MAGIC_D) begin
                        s.phase = PH_DONE; s.parse_status = ST_NO_TAG;
                    end
                end else if (n == 4'd2) begin
                    if (b != MAGIC_3) begin
                        s.phase = PH_DONE; s.parse_status = ST_NO_TAG;
                    end
                end else if (n == 4'd3) begin
                    if (b != 8'd3 && b != 8'd4) begin
                        s.phase = PH_DONE; s.parse_status = ST_INVALID;
                    end
                end else if (n == 4'd4) begin
                    if (b != 8'd0) begin
                        s.phase = PH_DONE; s.parse_status = ST_INVALID;
                    end
                end else if (n == 4'd5) begin
                    if ((b & FLAG_REJECT) != 8'd0) begin
                        s.phase = PH_DONE; s.parse_status = ST_UNSUPPORTED;
                    end
                end else begin
                    if (b[7]) begin
                        s.phase = PH_DONE; s.parse_status = ST_INVALID;
                    end else begin
                        s.tag_remaining = {s.tag_remaining[20:0], b[6:0]};
                    end
                end
                if (s.phase == PH_HEADER) begin
                    if (n >= 4'd9) begin
                        s.phase           = PH_FRAMEHDR;
                        s.header_count    = 4'd0;
                        s.frame_id        = 32'd0;
                        s.frame_remaining = 32'd0;
                        if (s.tag_remaining == 28'd0) begin
                            s.phase = PH_DONE; s.parse_status = ST_DONE;
                        end
                    end else begin
                        s.header_count = n + 4'd1;
                    end
                end
            end
            PH_FRAMEHDR, PH_BODY: begin
                s.tag_remaining = s.tag_remaining - 28'd1;
                if (s.phase == PH_FRAMEHDR) begin
                    // collect ID and size, then classify the frame
                    if (n < 4'd4) begin
                        if (b inside {[8'h30:8'h39], [8'h41:8'h5A], [8'h61:8'h7A]}) begin
                            s.frame_id = {s.frame_id[23:0], b};
                        end else begin
                            s.phase = PH_DONE; s.parse_status = ST_DONE;
                        end
                    end else if (n < 4'd8) begin
                        s.frame_remaining = {s.frame_remaining[23:0], b};
                    end
                    if (s.phase == PH_FRAMEHDR) begin
                        if (n >= 4'd9) begin
                            s.frame_kind     = classify(s.frame_id);
                            s.subfield_phase = (s.frame_kind == KIND_SKIP) ?
                                               SUB_CONTENT : SUB_START;
                            if (s.frame_remaining == 32'd0) begin
                                s.header_count = 4'd0;
                                s.frame_id     = 32'd0;
                            end else begin
                                s.phase = PH_BODY;
                            end
                        end else begin
                            s.header_count = n + 4'd1;
                        end
                    end
                end else begin
                    // body byte: tag content, strip leading subfields
                    s.frame_remaining = s.frame_remaining - 32'd1;
                    if (s.subfield_phase == SUB_CONTENT && s.frame_kind != KIND_SKIP) begin
                        kind = s.frame_kind;
                        pay  = b;
                    end
                    if (s.frame_kind == KIND_COMMENT) begin
                        if (s.subfield_phase < SUB_LANG_END) begin
                            s.subfield_phase = s.subfield_phase + 3'd1;
                        end else if (s.subfield_phase == SUB_LANG_END && b == 8'd0) begin
                            s.subfield_phase = SUB_CONTENT;
                        end
                    end else if (s.frame_kind == KIND_PICTURE) begin
                        case (s.subfield_phase)
                            SUB_START:   s.subfield_phase = SUB_MIME;
                            SUB_MIME:    if (b == 8'd0) s.subfield_phase = SUB_PICTYPE;
                            SUB_PICTYPE: s.subfield_phase = SUB_DESC;
                            SUB_DESC:    if (b == 8'd0) s.subfield_phase = SUB_CONTENT;
                            default:     s.subfield_phase = s.subfield_phase;
                        endcase
                    end else begin
                        s.subfield_phase = SUB_CONTENT;
                    end
                    if (s.frame_remaining == 32'd0) begin
                        last           = 1'b1;
                        s.phase        = PH_FRAMEHDR;
                        s.header_count = 4'd0;
                        s.frame_id     = 32'd0;
                    end
                end
                // end of tag, also mid-frame
                if (s.phase != PH_DONE && s.tag_remaining == 28'd0) begin
                    s.phase = PH_DONE; s.parse_status = ST_DONE;
                end
            end
            default: begin
                s = s;
            end
        endcase

        nxt               = s;
        res.field_kind    = kind;
        res.payload_byte  = pay;
        res.last_of_field = last;
        res.status        = (s.phase == PH_DONE) ? s.parse_status : ST_PARSING;
    end

endmodule

[tb/sv/id3_field_checker.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// id3_field_checker
// Follows the byte stream into the ID3v2 parser, works out the field result
// of every accepted byte and compares it with each result transaction.
// ---------------------------------------------------------------------------
module id3_field_checker import id3p_pkg::*; (
    input  logic aclk,
    input  logic aresetn,
    input  logic s_valid,
    input  logic s_ready,
    input  in_t  s_data,
    input  logic m_valid,
    input  logic m_ready,
    input  out_t m_data,
    output int   mismatches,
    output int   outstanding
);

    // Parser state as seen from the byte stream
    logic [1:0]  tag_phase;
    logic [3:0]  hdr_idx;
    logic [27:0] tag_left;
    logic [31:0] frm_left;
    logic [31:0] frm_id;
    logic [2:0]  frm_kind;
    logic [2:0]  sub_step;
    logic [2:0]  held_status;

    out_t field_results_q[$];
    int   err_cnt = 0;
    int   pend_cnt = 0;

    assign mismatches  = err_cnt;
    assign outstanding = pend_cnt;

    function automatic bit is_id_char(input logic [7:0] b);
        return (b >= "0" && b <= "9") || (b >= "A" && b <= "Z") || (b >= "a" && b <= "z");
    endfunction

    function automatic logic [2:0] kind_of_id(input logic [31:0] id);
        case (id)
            ID_COMM: return KIND_COMMENT;
            ID_TALB: return KIND_ALBUM;
            ID_TPE1: return KIND_ARTIST;
            ID_TIT2: return KIND_TITLE;
            ID_TRCK: return KIND_TRACK;
            ID_TYER: return KIND_YEAR;
            ID_APIC: return KIND_PICTURE;
            default: return KIND_SKIP;
        endcase
    endfunction

    // Step through the leading subfields of comment and picture bodies
    function automatic logic [2:0] next_sub(input logic [2:0] s, input logic [7:0] b,
                                            input logic [2:0] kind);
        logic [2:0] n;
        n = s;
        if (kind == KIND_COMMENT) begin
            if (s < SUB_LANG_END) n = s + 3'd1;
            else if (s == SUB_LANG_END && b == 8'h00) n = SUB_CONTENT;
        end else if (kind == KIND_PICTURE) begin
            case (s)
                SUB_START:   n = SUB_MIME;
                SUB_MIME:    if (b == 8'h00) n = SUB_PICTYPE;
                SUB_PICTYPE: n = SUB_DESC;
                SUB_DESC:    if (b == 8'h00) n = SUB_CONTENT;
                default:     n = s;
            endcase
        end else begin
            n = SUB_CONTENT;
        end
        return n;
    endfunction

    task clear_parser();
        tag_phase   = PH_HEADER;
        hdr_idx     = 4'd0;
        tag_left    = 28'd0;
        frm_left    = 32'd0;
        frm_id      = 32'd0;
        frm_kind    = KIND_SKIP;
        sub_step    = SUB_START;
        held_status = ST_PARSING;
    endtask

    task end_tag(input logic [2:0] code);
        tag_phase   = PH_DONE;
        held_status = code;
    endtask

    task open_frame();
        tag_phase = PH_FRAMEHDR;
        hdr_idx   = 4'd0;
        frm_id    = 32'd0;
        frm_left  = 32'd0;
    endtask

    // Advance the parser by one file byte and return its field result
    task parse_tag_byte(input in_t it, output out_t res);
        logic [7:0] b;
        logic [7:0] magic;
        logic [3:0] n;
        b   = it.data_byte;
        res = '0;
        if (it.start_of_file) clear_parser();
        case (tag_phase)
            PH_HEADER: begin
                n = hdr_idx;
                if (n < 4'd3) begin
                    magic = (n == 4'd0) ? MAGIC_I : (n == 4'd1) ? MAGIC_D : MAGIC_3;
                    if (b != magic) end_tag(ST_NO_TAG);
                end else if (n == 4'd3) begin
                    if (b != 8'd3 && b != 8'd4) end_tag(ST_INVALID);
                end else if (n == 4'd4) begin
                    if (b != 8'd0) end_tag(ST_INVALID);
                end else if (n == 4'd5) begin
                    if ((b & FLAG_REJECT) != 8'd0) end_tag(ST_UNSUPPORTED);
                end else if (b[7]) begin
                    end_tag(ST_INVALID);
                end else begin
                    tag_left = {tag_left[20:0], b[6:0]};
                end
                if (tag_phase == PH_HEADER) begin
                    if (n >= 4'd9) begin
                        open_frame();
                        if (tag_left == 28'd0) end_tag(ST_DONE);
                    end else begin
                        hdr_idx = n + 4'd1;
                    end
                end
            end
            PH_FRAMEHDR, PH_BODY: begin
                tag_left = tag_left - 28'd1;
                if (tag_phase == PH_FRAMEHDR) begin
                    n = hdr_idx;
                    if (n < 4'd4) begin
                        if (!is_id_char(b)) end_tag(ST_DONE);
                        else frm_id = {frm_id[23:0], b};
                    end else if (n < 4'd8) begin
                        frm_left = {frm_left[23:0], b};
                    end
                    if (tag_phase == PH_FRAMEHDR) begin
                        if (n >= 4'd9) begin
                            frm_kind = kind_of_id(frm_id);
                            sub_step = (frm_kind == KIND_SKIP) ? SUB_CONTENT : SUB_START;
                            if (frm_left == 32'd0) open_frame();
                            else tag_phase = PH_BODY;
                        end else begin
                            hdr_idx = n + 4'd1;
                        end
                    end
                end else begin
                    frm_left = frm_left - 32'd1;
                    if (sub_step == SUB_CONTENT && frm_kind != KIND_SKIP) begin
                        res.field_kind   = frm_kind;
                        res.payload_byte = b;
                    end
                    sub_step = next_sub(sub_step, b, frm_kind);
                    if (frm_left == 32'd0) begin
                        res.last_of_field = 1'b1;
                        open_frame();
                    end
                end
                if (tag_phase != PH_DONE && tag_left == 28'd0) end_tag(ST_DONE);
            end
            default: ;
        endcase
        res.status = (tag_phase == PH_DONE) ? held_status : ST_PARSING;
    endtask

    // Predict on each byte transaction, compare on each result transaction
    always @(posedge aclk) begin : watch
        out_t predicted;
        out_t want;
        if (!aresetn) begin
            clear_parser();
            field_results_q.delete();
        end else begin
            if (s_valid && s_ready) begin
                parse_tag_byte(s_data, predicted);
                field_results_q.push_back(predicted);
            end
            if (m_valid && m_ready) begin
                if (field_results_q.size() == 0) begin
                    $display("%0t: unexpected result, act %0d/%h/%0d/%0d (kind/byte/last/status)",
                             $time, m_data.field_kind, m_data.payload_byte,
                             m_data.last_of_field, m_data.status);
                    err_cnt = err_cnt + 1;
                end else begin
                    want = field_results_q.pop_front();
                    if (m_data !== want) begin
                        $display("%0t: exp %0d/%h/%0d/%0d act %0d/%h/%0d/%0d (kind/byte/last/status)",
                                 $time, want.field_kind, want.payload_byte,
                                 want.last_of_field, want.status,
                                 m_data.field_kind, m_data.payload_byte,
                                 m_data.last_of_field, m_data.status);
                        err_cnt = err_cnt + 1;
                    end
                end
            end
        end
        pend_cnt <= field_results_q.size();
    end

endmodule

[tb/sv/id3v2_tag_stream_parser_tb.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// id3v2_tag_stream_parser_tb
// Feeds the ID3v2 parser directed broken headers, then random tag files
// (mostly well formed, some corrupted) under several idle and stall phases.
// ---------------------------------------------------------------------------
module id3v2_tag_stream_parser_tb;
    import id3p_pkg::*;

    logic aclk;
    logic aresetn;
    logic s_valid;
    logic s_ready;
    in_t  s_data;
    logic m_valid;
    logic m_ready;
    out_t m_data;
    int   mismatches;
    int   outstanding;

    int src_idle_pct;
    int snk_stall_pct = 0;
    int hold_token = 0;
    int hold_seen = 0;
    int hold_left = 0;
    int bytes_sent = 0;

    logic [7:0] file_bytes[$];
    logic [7:0] tag_body[$];

    id3v2_tag_stream_parser u_top (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    id3_field_checker u_checker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // Receiver: random stalls, plus a long hold-off whenever one is requested
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_token != hold_seen) begin
            hold_seen <= hold_token;
            hold_left <= 80;
            m_ready   <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_ready   <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(0, 99) >= snk_stall_pct);
        end
    end

    // Offer one byte transaction and hold it until accepted
    task send_byte(input in_t it);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= it;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        bytes_sent = bytes_sent + 1;
    endtask

    task send_file(input bit restarts);
        in_t it;
        int  i;
        for (i = 0; i < file_bytes.size(); i++) begin
            it.data_byte     = file_bytes[i];
            it.start_of_file = (i == 0) || (restarts && $urandom_range(0, 299) == 0);
            send_byte(it);
        end
    endtask

    // Stop offering and wait until every predicted result has come back
    task drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
    endtask

    // Build one random tag file: header, frames, padding, trailing bytes
    task make_tag_file();
        logic [7:0]  frame_q[$];
        logic [31:0] fid;
        logic [31:0] fsize;
        logic [27:0] tsize;
        logic [2:0]  kind;
        int          nfr, k, j, r, sel, len;
        tag_body.delete();
        file_bytes.delete();
        nfr = $urandom_range(0, 4);
        for (k = 0; k < nfr; k++) begin
            frame_q.delete();
            sel  = $urandom_range(0, 99);
            kind = 3'($urandom_range(0, 7));
            case (kind)
                KIND_COMMENT: fid = ID_COMM;
                KIND_ALBUM:   fid = ID_TALB;
                KIND_ARTIST:  fid = ID_TPE1;
                KIND_TITLE:   fid = ID_TIT2;
                KIND_TRACK:   fid = ID_TRCK;
                KIND_YEAR:    fid = ID_TYER;
                KIND_PICTURE: fid = ID_APIC;
                default: begin
                    for (j = 0; j < 4; j++) begin
                        r = $urandom_range(0, 61);
                        fid[8*(3-j) +: 8] = (r < 10) ? 8'(48 + r) :
                                            (r < 36) ? 8'(65 + r - 10) : 8'(97 + r - 36);
                    end
                end
            endcase
            // a stray byte in the ID ends the tag like padding
            if (sel < 6) fid[8*$urandom_range(0, 3) +: 8] = 8'($urandom_range(0, 47));
            if (kind == KIND_COMMENT) begin
                for (j = 0; j < 4; j++) frame_q.push_back(8'($urandom_range(0, 255)));
                len = $urandom_range(0, 3);
                for (j = 0; j < len; j++) frame_q.push_back(8'($urandom_range(1, 255)));
                frame_q.push_back(8'h00);
            end else if (kind == KIND_PICTURE) begin
                frame_q.push_back(8'($urandom_range(0, 255)));
                len = $urandom_range(0, 3);
                for (j = 0; j < len; j++) frame_q.push_back(8'($urandom_range(1, 255)));
                frame_q.push_back(8'h00);
                frame_q.push_back(8'($urandom_range(0, 255)));
                len = $urandom_range(0, 2);
                for (j = 0; j < len; j++) frame_q.push_back(8'($urandom_range(1, 255)));
                frame_q.push_back(8'h00);
            end
            len = $urandom_range(0, 6);
            for (j = 0; j < len; j++) frame_q.push_back(8'($urandom_range(0, 255)));
            fsize = frame_q.size();
            if (sel >= 96) fsize = $urandom();
            else if (sel >= 90) fsize = $urandom_range(0, frame_q.size());
            for (j = 3; j >= 0; j--) tag_body.push_back(fid[8*j +: 8]);
            for (j = 3; j >= 0; j--) tag_body.push_back(fsize[8*j +: 8]);
            tag_body.push_back(8'($urandom_range(0, 255)));
            tag_body.push_back(8'($urandom_range(0, 255)));
            foreach (frame_q[j]) tag_body.push_back(frame_q[j]);
        end
        len = $urandom_range(0, 3);
        for (j = 0; j < len; j++) tag_body.push_back(8'h00);

        // choose the tag size: exact, short, long or the largest syncsafe value
        len = tag_body.size();
        sel = $urandom_range(0, 99);
        if (sel < 70) tsize = 28'(len);
        else if (sel < 88) tsize = 28'($urandom_range(0, len));
        else if (sel < 96) tsize = 28'(len + $urandom_range(1, 8));
        else tsize = 28'hFFF_FFFF;

        file_bytes.push_back(MAGIC_I);
        file_bytes.push_back(MAGIC_D);
        file_bytes.push_back(MAGIC_3);
        file_bytes.push_back($urandom_range(0, 1) ? 8'h03 : 8'h04);
        file_bytes.push_back(8'h00);
        file_bytes.push_back($urandom_range(0, 1) ? 8'h80 : 8'h00);
        file_bytes.push_back({1'b0, tsize[27:21]});
        file_bytes.push_back({1'b0, tsize[20:14]});
        file_bytes.push_back({1'b0, tsize[13:7]});
        file_bytes.push_back({1'b0, tsize[6:0]});
        // corrupt the header now and then
        if ($urandom_range(0, 99) < 12)
            file_bytes[$urandom_range(0, 9)] = 8'($urandom_range(0, 255));
        foreach (tag_body[j]) file_bytes.push_back(tag_body[j]);
        len = $urandom_range(0, 3);
        for (j = 0; j < len; j++) file_bytes.push_back(8'($urandom_range(0, 255)));
    endtask

    initial begin : stimulus
        int ph, target;
        s_valid      = 1'b0;
        s_data       = '0;
        aresetn      = 1'b0;
        src_idle_pct = 0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: bad magic, bad version, unsupported flags, oversized
        // size byte and an empty tag
        file_bytes = '{8'h58, 8'hFF};
        send_file(1'b0);
        file_bytes = '{MAGIC_I, MAGIC_D, MAGIC_3, 8'h02};
        send_file(1'b0);
        file_bytes = '{MAGIC_I, MAGIC_D, MAGIC_3, 8'h03, 8'h00, 8'h40};
        send_file(1'b0);
        file_bytes = '{MAGIC_I, MAGIC_D, MAGIC_3, 8'h04, 8'h00, 8'h80, 8'h80};
        send_file(1'b0);
        file_bytes = '{MAGIC_I, MAGIC_D, MAGIC_3, 8'h03, 8'h00, 8'h00,
                       8'h00, 8'h00, 8'h00, 8'h00};
        send_file(1'b0);
        drain();

        // Random files under each idle and stall mix
        for (ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin src_idle_pct = 0;  snk_stall_pct <= 0;  end
                1: begin src_idle_pct = 68; snk_stall_pct <= 0;  end
                2: begin src_idle_pct = 0;  snk_stall_pct <= 68; end
                default: begin src_idle_pct = 9; snk_stall_pct <= 9; end
            endcase
            hold_token <= hold_token + 1;
            target = bytes_sent + 225;
            while (bytes_sent < target) begin
                make_tag_file();
                send_file(1'b1);
            end
            drain();
        end

        repeat (8) @(posedge aclk);
        if (mismatches == 0 && outstanding == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    initial begin : watchdog
        #2_000_000;
        $display("== FAIL ==");
        $finish;
    end

endmodule

[id3v2_tag_stream_parser.f]
hdl/id3p_pkg.sv
hdl/id3p_step.sv
hdl/id3v2_tag_stream_parser.sv
tb/sv/id3_field_checker.sv
tb/sv/id3v2_tag_stream_parser_tb.sv
